// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the page frame allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante |-> cons on the rising clock edge, off during reset
`define BPFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante |=> cons on the rising clock edge, off during reset
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BPFA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/bpfa_pkg.sv =====
// Shared types, constants and microcode table of the page frame allocator.
// No dependencies; used by the sequencer, datapath and top level.
package bpfa_pkg;

  localparam int DEF_TOTAL_PAGES = 512;
  localparam int DEF_MAP_WORDS   = 16;
  localparam int WORD_BITS       = 32;
  localparam int BIT_W           = 5;
  localparam int PAGE_W          = 9;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 10;
  localparam int FUP_W           = 10;
  localparam int SCAN_CHUNK      = 8;
  localparam int CHUNK_AW        = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [FUP_W-1:0] FUP_RESET = 10'd1;

  // register index (paddr above the byte offset)
  localparam logic [CFG_ADDR_W-3:0] REG_FUP = 1'b0;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ALLOC, S_FREE_RD, S_FREE_WR, S_REBUILD, S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    ACT_NOP, ACT_ACCEPT, ACT_SCAN, ACT_ALLOC, ACT_FREE_RD, ACT_FREE_WR,
    ACT_REBUILD, ACT_EMIT
  } act_t;

  typedef enum logic [1:0] {
    C_ACCEPT, C_HIT, C_ALWAYS, C_SLOT
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic              in_valid;
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic              last;
    logic              slot_free;
  } flags_t;

  // microprogram: one control word per step
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    case (s)
      S_IDLE:    c = '{act: ACT_ACCEPT,  cond: C_ACCEPT, target: S_IDLE};
      S_SCAN:    c = '{act: ACT_SCAN,    cond: C_HIT,    target: S_ALLOC};
      S_ALLOC:   c = '{act: ACT_ALLOC,   cond: C_ALWAYS, target: S_EMIT};
      S_FREE_RD: c = '{act: ACT_FREE_RD, cond: C_ALWAYS, target: S_FREE_WR};
      S_FREE_WR: c = '{act: ACT_FREE_WR, cond: C_ALWAYS, target: S_EMIT};
      S_REBUILD: c = '{act: ACT_REBUILD, cond: C_ALWAYS, target: S_EMIT};
      S_EMIT:    c = '{act: ACT_EMIT,    cond: C_SLOT,   target: S_IDLE};
      default:   c = '{act: ACT_NOP,     cond: C_ALWAYS, target: S_IDLE};
    endcase
    return c;
  endfunction

  // entry point of each request kind; unused kind goes straight to result
  function automatic step_t dispatch(logic [KIND_W-1:0] kind);
    step_t s;
    case (kind)
      KIND_ALLOC:   s = S_SCAN;
      KIND_FREE:    s = S_FREE_RD;
      KIND_REBUILD: s = S_REBUILD;
      default:      s = S_EMIT;
    endcase
    return s;
  endfunction

  // {any, index of lowest set bit}
  function automatic logic [CHUNK_AW:0] lowest8(logic [SCAN_CHUNK-1:0] v);
    logic [CHUNK_AW-1:0] pos;
    pos = '0;
    for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = CHUNK_AW'(i);
      end
    end
    return {|v, pos};
  endfunction

endpackage

// ===== hw/rtl/bpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free bitmap words.
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bpfa_seq.sv =====
// Microcode sequencer: step register, control word lookup, conditional jumps.
// Depends on bpfa_pkg.
module bpfa_seq (
  input  logic            clk,
  input  logic            rst,
  input  bpfa_pkg::flags_t flags,
  output bpfa_pkg::ctl_t   ctl
);

  bpfa_pkg::step_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bpfa_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctl       = bpfa_pkg::ucode(step);
    step_next = step;
    case (ctl.cond)
      bpfa_pkg::C_ACCEPT: begin
        if (flags.in_valid) begin
          step_next = bpfa_pkg::dispatch(flags.kind);
        end
      end
      bpfa_pkg::C_HIT: begin
        if (flags.hit) begin
          step_next = ctl.target;
        end else if (flags.last) begin
          step_next = bpfa_pkg::S_EMIT;
        end
      end
      bpfa_pkg::C_ALWAYS: step_next = ctl.target;
      bpfa_pkg::C_SLOT: begin
        if (flags.slot_free) begin
          step_next = ctl.target;
        end
      end
      default: step_next = bpfa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/bpfa_dp.sv =====
// Datapath: bitmap RAM, word valid and nonzero flags, count, result register.
// Depends on bpfa_pkg and bpfa_ram; driven by the control word of bpfa_seq.
module bpfa_dp #(
  parameter int TOTAL_PAGES = bpfa_pkg::DEF_TOTAL_PAGES,
  parameter int MAP_WORDS   = bpfa_pkg::DEF_MAP_WORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bpfa_pkg::ctl_t                    ctl,
  input  logic                              in_valid,
  input  logic [bpfa_pkg::KIND_W-1:0]       kind,
  input  logic [bpfa_pkg::PAGE_W-1:0]       page,
  input  logic [bpfa_pkg::FUP_W-1:0]        fup,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [bpfa_pkg::PAGE_W-1:0]       page_out,
  output logic [bpfa_pkg::STATUS_W-1:0]     status,
  output logic [bpfa_pkg::COUNT_W-1:0]      free_count,
  output bpfa_pkg::flags_t                  flags
);

  localparam int MAP_BITS   = MAP_WORDS * bpfa_pkg::WORD_BITS;
  localparam int PAGE_LIMIT = (TOTAL_PAGES < MAP_BITS) ? TOTAL_PAGES : MAP_BITS;
  localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W      = $clog2(PAGE_LIMIT + 1);
  localparam int NCHUNK     = (MAP_WORDS + bpfa_pkg::SCAN_CHUNK - 1) / bpfa_pkg::SCAN_CHUNK;
  localparam int CH_AW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SCAN_W     = CH_AW + bpfa_pkg::CHUNK_AW;
  localparam int PNUM_W     = MAP_AW + bpfa_pkg::BIT_W;
  localparam int WB         = bpfa_pkg::WORD_BITS;

  // request and progress registers
  logic [bpfa_pkg::PAGE_W-1:0]   op_page;
  logic [MAP_AW-1:0]             word_idx;
  logic                          in_range;
  logic [CH_AW-1:0]              chunk;
  logic [bpfa_pkg::PAGE_W-1:0]   res_page;
  logic [bpfa_pkg::STATUS_W-1:0] res_status;

  // map state: words not written since rebuild read as the rebuild pattern
  logic [MAP_WORDS-1:0]          valid;
  logic [MAP_WORDS-1:0]          nz;
  logic                          rebuilt;
  logic [bpfa_pkg::FUP_W-1:0]    rb_fup;
  logic [CNT_W-1:0]              count;

  logic [NCHUNK*bpfa_pkg::SCAN_CHUNK-1:0] nz_pad;
  logic [bpfa_pkg::SCAN_CHUNK-1:0]        chunk_bits;
  logic [bpfa_pkg::CHUNK_AW:0]            sc;
  logic [SCAN_W-1:0]                      hit_full;
  logic [MAP_AW-1:0]                      hit_word;
  logic                                   hit, last, slot_free;
  logic [31:0]                            page_wd;
  logic [MAP_AW-1:0]                      fr_word;
  logic [MAP_AW-1:0]                      raddr;
  logic [WB-1:0]                          rdata, pat, eff;
  logic [PNUM_W-1:0]                      pnum;
  logic [3:0]                             byte_any;
  logic [1:0]                             byte_sel;
  logic [bpfa_pkg::CHUNK_AW:0]            bsc;
  logic [bpfa_pkg::BIT_W-1:0]             bpos;
  logic [WB-1:0]                          new_alloc, fmask, new_free;
  logic                                   dup;
  logic [31:0]                            alloc_pg, cnt32, fup32;
  logic [CNT_W-1:0]                       cnt_rb;
  logic [MAP_WORDS-1:0]                   nz_rb;
  logic                                   we;
  logic [WB-1:0]                          wdata;

  // first-fit scan over nonzero flags, eight words a cycle
  always_comb begin
    nz_pad     = (NCHUNK*bpfa_pkg::SCAN_CHUNK)'(nz);
    chunk_bits = nz_pad[int'(chunk)*bpfa_pkg::SCAN_CHUNK +: bpfa_pkg::SCAN_CHUNK];
    sc         = bpfa_pkg::lowest8(chunk_bits);
    hit        = sc[bpfa_pkg::CHUNK_AW];
    hit_full   = {chunk, sc[bpfa_pkg::CHUNK_AW-1:0]};
    hit_word   = hit_full[MAP_AW-1:0];
    last       = (chunk == CH_AW'(NCHUNK - 1));
    slot_free  = !out_valid || !out_stall;
  end

  always_comb begin
    page_wd = 32'(op_page) >> bpfa_pkg::BIT_W;
    fr_word = page_wd[MAP_AW-1:0];
    raddr   = (ctl.act == bpfa_pkg::ACT_SCAN) ? hit_word : fr_word;
  end

  bpfa_ram #(
    .WIDTH(WB),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(word_idx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // effective word: RAM data once written, else what rebuild left there
  always_comb begin
    pnum = '0;
    for (int b = 0; b < WB; b++) begin
      pnum   = {word_idx, bpfa_pkg::BIT_W'(b)};
      pat[b] = rebuilt && (32'(pnum) >= 32'(rb_fup)) && (32'(pnum) < PAGE_LIMIT);
    end
    eff = valid[word_idx] ? rdata : pat;
  end

  // lowest set bit: byte first, then bit in byte
  always_comb begin
    byte_sel = '0;
    for (int k = 0; k < 4; k++) begin
      byte_any[k] = |eff[k*8 +: 8];
    end
    for (int k = 3; k >= 0; k--) begin
      if (byte_any[k]) begin
        byte_sel = 2'(k);
      end
    end
    bsc       = bpfa_pkg::lowest8(eff[int'(byte_sel)*8 +: 8]);
    bpos      = {byte_sel, bsc[bpfa_pkg::CHUNK_AW-1:0]};
    new_alloc = eff & ~(WB'(1) << bpos);
    alloc_pg  = 32'({word_idx, bpos});
    fmask     = WB'(1) << op_page[bpfa_pkg::BIT_W-1:0];
    dup       = |(eff & fmask);
    new_free  = eff | fmask;
  end

  always_comb begin
    we    = (ctl.act == bpfa_pkg::ACT_ALLOC) ||
            ((ctl.act == bpfa_pkg::ACT_FREE_WR) && in_range && !dup);
    wdata = (ctl.act == bpfa_pkg::ACT_ALLOC) ? new_alloc : new_free;
  end

  // rebuild: count and per-word nonzero flags straight from first_user_page
  always_comb begin
    fup32  = 32'(fup);
    cnt_rb = (fup32 < PAGE_LIMIT) ? CNT_W'(PAGE_LIMIT - fup32) : '0;
    for (int w = 0; w < MAP_WORDS; w++) begin
      nz_rb[w] = (32'(w*WB + WB - 1) >= fup32) && (w*WB < PAGE_LIMIT) &&
                 (fup32 < PAGE_LIMIT);
    end
    cnt32 = 32'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      nz        <= '0;
      rebuilt   <= 1'b0;
      count     <= '0;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && ctl.act != bpfa_pkg::ACT_EMIT) begin
        out_valid <= 1'b0;
      end
      case (ctl.act)
        bpfa_pkg::ACT_ACCEPT: begin
          if (in_valid) begin
            op_page    <= page;
            res_page   <= '0;
            res_status <= bpfa_pkg::STATUS_OK;
            chunk      <= '0;
          end
        end
        bpfa_pkg::ACT_SCAN: begin
          if (hit) begin
            word_idx <= hit_word;
          end else if (last) begin
            res_status <= bpfa_pkg::STATUS_NOFREE;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        bpfa_pkg::ACT_ALLOC: begin
          valid[word_idx] <= 1'b1;
          nz[word_idx]    <= |new_alloc;
          if (count != '0) begin
            count <= count - 1'b1;
          end
          res_page <= alloc_pg[bpfa_pkg::PAGE_W-1:0];
        end
        bpfa_pkg::ACT_FREE_RD: begin
          word_idx <= fr_word;
          in_range <= (32'(op_page) < PAGE_LIMIT);
        end
        bpfa_pkg::ACT_FREE_WR: begin
          if (in_range) begin
            if (dup) begin
              res_status <= bpfa_pkg::STATUS_DUP;
            end else begin
              valid[word_idx] <= 1'b1;
              nz[word_idx]    <= 1'b1;
              count           <= count + 1'b1;
            end
          end
        end
        bpfa_pkg::ACT_REBUILD: begin
          valid   <= '0;
          nz      <= nz_rb;
          rebuilt <= 1'b1;
          rb_fup  <= fup;
          count   <= cnt_rb;
        end
        bpfa_pkg::ACT_EMIT: begin
          // a result leaving this edge is replaced by the new one
          if (slot_free) begin
            out_valid  <= 1'b1;
            page_out   <= res_page;
            status     <= res_status;
            free_count <= cnt32[bpfa_pkg::COUNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    flags.in_valid  = in_valid;
    flags.kind      = kind;
    flags.hit       = hit;
    flags.last      = last;
    flags.slot_free = slot_free;
  end

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// First-fit bitmap page frame allocator; one request at a time, one result each.
// Steps per request: allocate scans eight map words per step for the first nonzero word,
// then reads that RAM word and searches it for its lowest set bit; free reads the word and
// writes it back; rebuild resets the map from first_user_page; an unused kind goes straight
// to the emit step, which waits while the result channel stalls. Synchronous reset:
// map empty (per-word valid flags), count zero, first_user_page 1. Uses bpfa_* files.
`include "assert_macros.svh"

module bitmap_page_frame_allocator #(
  parameter int TOTAL_PAGES = bpfa_pkg::DEF_TOTAL_PAGES,
  parameter int MAP_WORDS   = bpfa_pkg::DEF_MAP_WORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpfa_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bpfa_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bpfa_pkg::KIND_W-1:0]       kind,
  input  logic [bpfa_pkg::PAGE_W-1:0]       page,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpfa_pkg::PAGE_W-1:0]       page_out,
  output logic [bpfa_pkg::STATUS_W-1:0]     status,
  output logic [bpfa_pkg::COUNT_W-1:0]      free_count
);

  logic [bpfa_pkg::FUP_W-1:0] first_user_page;
  logic                       fup_sel;
  bpfa_pkg::ctl_t             ctl;
  bpfa_pkg::flags_t           flags;

  // one register; word index is paddr above the byte offset
  assign fup_sel = (paddr[bpfa_pkg::CFG_ADDR_W-1:2] == bpfa_pkg::REG_FUP);
  assign pready  = 1'b1;
  assign prdata  = fup_sel ? bpfa_pkg::CFG_DATA_W'(first_user_page) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_user_page <= bpfa_pkg::FUP_RESET;
    end else if (psel && penable && pwrite && pready && fup_sel) begin
      first_user_page <= pwdata[bpfa_pkg::FUP_W-1:0];
    end
  end

  // request taken only in the idle step of the microprogram
  assign in_stall = (ctl.act != bpfa_pkg::ACT_ACCEPT);

  bpfa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .ctl  (ctl)
  );

  bpfa_dp #(
    .TOTAL_PAGES(TOTAL_PAGES),
    .MAP_WORDS  (MAP_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .kind      (kind),
    .page      (page),
    .fup       (first_user_page),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .page_out  (page_out),
    .status    (status),
    .free_count(free_count),
    .flags     (flags)
  );

  // a taken request makes the channel stall in the following cycle
  `BPFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // failed allocation reports page zero
  `BPFA_ASSERT_IMPL(a_nofree_page_zero, clk, rst, out_valid && status == bpfa_pkg::STATUS_NOFREE, page_out == '0)
  // a new result only comes out of the emit step
  `BPFA_ASSERT_IMPL(a_result_from_emit, clk, rst, $rose(out_valid), $past(ctl.act == bpfa_pkg::ACT_EMIT))

endmodule
